/* src/glc_pkg.sv */
// Shared types, character codes and helpers for the G-code line cleaner.
// No dependencies; the top level, the checker and the testbench import this package.
package glc_pkg;

	// Longest source line in bytes, carriage returns not counted (1 to 4096)
	localparam int MAX_LINE = 256;
	localparam int LEN_W    = $clog2(MAX_LINE + 1);

	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] DEPTH_MAX  = 8'hFF;
	localparam logic [8:0] KLEN_MAX   = 9'h1FF;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_FLUSH   = 2'd1,
		OP_RESTART = 2'd2
	} glc_op_t;

	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_ACCEPT   = 2'd1,
		KIND_DISCARD  = 2'd2,
		KIND_TOO_LONG = 2'd3
	} glc_kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_char;
		logic [31:0] line_number;
		logic [8:0]  kept_length;
	} glc_result_t;

	// Kept count as reported on the result channel, saturated at 511
	function automatic logic [8:0] sat_len(input logic [LEN_W-1:0] v);
		logic [LEN_W+8:0] wide;
		wide = {9'd0, v};
		if (wide > (LEN_W + 9)'(KLEN_MAX))
			return KLEN_MAX;
		else
			return wide[8:0];
	endfunction

endpackage

/* src/glc_if.sv */
// Valid/ready channel interfaces for the G-code line cleaner.
// Source byte request channel and result request channel; no dependencies.
interface glc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] in_byte;

	modport source (output valid, output op, output in_byte, input ready);
	modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface glc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_char;
	logic [31:0] line_number;
	logic [8:0]  kept_length;

	modport source (output valid, output kind, output out_char, output line_number,
		output kept_length, input ready);
	modport sink   (input valid, input kind, input out_char, input line_number,
		input kept_length, output ready);
endinterface

/* src/gcode_line_cleaner.sv */
// Top level of the G-code line cleaner: per-line state and a two-entry result stage.
// Depends on glc_pkg and the channel interfaces in glc_if.sv.
//
//   channel  | dir | payload                                      | request accepted when
//   ---------+-----+----------------------------------------------+----------------------
//   feed     | in  | op, in_byte                                  | valid && ready
//   result   | out | kind, out_char, line_number, kept_length     | valid && ready
//
// One request is taken per cycle while feed.ready is high; its result (if any) goes to the result stage.
// The per-line state update is a single compare/increment step on the accepted
// byte, computed combinationally and loaded straight into the state registers.
// The result stage holds two entries: feed.ready drops only when both are full,
// i.e. after two results are left waiting on a stalled result channel.
// arst_n clears all line state, the line counter, the halt flag and the result stage.
module gcode_line_cleaner
	import glc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	glc_in_if.sink        feed,
	glc_out_if.source     result
);

	// Per-line state
	logic [LEN_W-1:0] raw_length_q, raw_length_d;
	logic [LEN_W-1:0] kept_count_q, kept_count_d;
	logic [7:0]       paren_depth_q, paren_depth_d;
	logic             rest_comment_q, rest_comment_d;
	logic             first_pct_q, first_pct_d;
	// Job state
	logic [31:0]      lines_ended_q, lines_ended_d;
	logic             halted_q, halted_d;

	// Result stage: main entry drives the port, skid entry catches overflow
	logic             out_valid_q, skid_valid_q;
	glc_result_t      out_q, skid_q;

	logic             feed_take, res_take, res_push, load_out, line_ok;
	glc_result_t      res;

	assign feed.ready = !skid_valid_q;
	assign feed_take  = feed.valid && feed.ready;
	assign res_take   = out_valid_q && result.ready;

	// Verdict for the line being closed: something kept, and not a lone '%'
	assign line_ok = (kept_count_q != '0) &&
		!((kept_count_q == LEN_W'(1)) && first_pct_q);

	always_comb begin
		raw_length_d  = raw_length_q;
		kept_count_d  = kept_count_q;
		paren_depth_d = paren_depth_q;
		rest_comment_d = rest_comment_q;
		first_pct_d   = first_pct_q;
		lines_ended_d = lines_ended_q;
		halted_d      = halted_q;
		res_push      = 1'b0;
		res           = '0;

		if (feed_take) begin
			unique case (feed.op)
				OP_RESTART: begin
					raw_length_d   = '0;
					kept_count_d   = '0;
					paren_depth_d  = '0;
					rest_comment_d = 1'b0;
					first_pct_d    = 1'b0;
					lines_ended_d  = '0;
					halted_d       = 1'b0;
				end
				OP_FLUSH, OP_BYTE: begin
					if (!halted_q) begin
						if ((feed.op == OP_FLUSH && raw_length_q != '0) ||
							(feed.op == OP_BYTE && feed.in_byte == CH_LF)) begin
							// end of line: verdict carries the new line count
							lines_ended_d    = lines_ended_q + 32'd1;
							raw_length_d     = '0;
							kept_count_d     = '0;
							paren_depth_d    = '0;
							rest_comment_d   = 1'b0;
							first_pct_d      = 1'b0;
							res_push         = 1'b1;
							res.kind         = line_ok ? KIND_ACCEPT : KIND_DISCARD;
							res.line_number  = lines_ended_q + 32'd1;
							res.kept_length  = sat_len(kept_count_q);
						end else if (feed.op == OP_BYTE && feed.in_byte != CH_CR) begin
							if (raw_length_q >= LEN_W'(MAX_LINE)) begin
								// overlong line is fatal until restart
								halted_d        = 1'b1;
								res_push        = 1'b1;
								res.kind        = KIND_TOO_LONG;
								res.line_number = lines_ended_q;
								res.kept_length = sat_len(kept_count_q);
							end else begin
								raw_length_d = raw_length_q + LEN_W'(1);
								if (rest_comment_q) begin
									// rest of line after ';' is dropped
								end else if (feed.in_byte == CH_LPAREN) begin
									if (paren_depth_q != DEPTH_MAX)
										paren_depth_d = paren_depth_q + 8'd1;
								end else if (feed.in_byte == CH_RPAREN) begin
									if (paren_depth_q != '0)
										paren_depth_d = paren_depth_q - 8'd1;
								end else if (paren_depth_q != '0) begin
									// inside a parenthesized comment
								end else if (feed.in_byte == CH_SEMI) begin
									rest_comment_d = 1'b1;
								end else if (feed.in_byte > CH_SPACE) begin
									if (kept_count_q == '0)
										first_pct_d = (feed.in_byte == CH_PERCENT);
									kept_count_d    = kept_count_q + LEN_W'(1);
									res_push        = 1'b1;
									res.kind        = KIND_CHAR;
									res.out_char    = feed.in_byte;
									res.line_number = lines_ended_q;
									res.kept_length = sat_len(kept_count_q + LEN_W'(1));
								end
							end
						end
					end
				end
				default: begin
					// unused op code: no effect
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_length_q   <= '0;
			kept_count_q   <= '0;
			paren_depth_q  <= '0;
			rest_comment_q <= 1'b0;
			first_pct_q    <= 1'b0;
			lines_ended_q  <= '0;
			halted_q       <= 1'b0;
		end else begin
			raw_length_q   <= raw_length_d;
			kept_count_q   <= kept_count_d;
			paren_depth_q  <= paren_depth_d;
			rest_comment_q <= rest_comment_d;
			first_pct_q    <= first_pct_d;
			lines_ended_q  <= lines_ended_d;
			halted_q       <= halted_d;
		end
	end

	// A new result goes to the main entry when it is empty or being drained
	// with nothing behind it; otherwise it parks in the skid entry.
	assign load_out = !out_valid_q || (res_take && !skid_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			// main entry: refilled by a new result, else emptied when drained alone
			if (res_push && load_out)
				out_valid_q <= 1'b1;
			else if (res_take && !skid_valid_q)
				out_valid_q <= 1'b0;
			// skid entry: filled on overflow, emptied when it moves forward
			if (res_push && !load_out)
				skid_valid_q <= 1'b1;
			else if (res_take && skid_valid_q)
				skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && skid_valid_q)
			out_q <= skid_q;
		if (res_push && load_out)
			out_q <= res;
		if (res_push && !load_out)
			skid_q <= res;
	end

	assign result.valid       = out_valid_q;
	assign result.kind        = out_q.kind;
	assign result.out_char    = out_q.out_char;
	assign result.line_number = out_q.line_number;
	assign result.kept_length = out_q.kept_length;

endmodule

/* src/glc_checker.sv */
// Port-level checks for the G-code line cleaner, bound to its top level.
// Depends on glc_pkg and gcode_line_cleaner.
module glc_checker
	import glc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        feed_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  kind,
	input logic [7:0]  out_char,
	input logic [31:0] line_number,
	input logic [8:0]  kept_length
);

	// a stalled result keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(kind) && $stable(out_char) &&
			$stable(line_number) && $stable(kept_length))
		else $error("result payload changed while stalled");

	// feed backpressure only while the result channel holds a valid result
	a_ready_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!feed_ready |-> result_valid)
		else $error("feed stalled with empty result stage");

	// a full stage stays full until the result side drains it
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!feed_ready && !result_ready |=> !feed_ready)
		else $error("result stage lost an entry while stalled");

	// kept characters lie above the space code and are never comment delimiters
	a_kept_char: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_CHAR |->
			out_char > CH_SPACE && out_char != CH_SEMI &&
			out_char != CH_LPAREN && out_char != CH_RPAREN && kept_length != 9'd0)
		else $error("kept character is whitespace or comment syntax");

endmodule

bind gcode_line_cleaner glc_checker u_glc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.feed_ready   (feed.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.kind         (result.kind),
	.out_char     (result.out_char),
	.line_number  (result.line_number),
	.kept_length  (result.kept_length)
);

/* tb/testbench.sv */
// Self-checking testbench for gcode_line_cleaner: a directed table, then random G-code lines.
// Depends on glc_pkg, the channel interfaces in glc_if.sv and the block's top level.
module testbench;
	import glc_pkg::*;

	// op code the block must ignore
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         ITEMS      = 1550;
	// cycles with no handshake on either channel before the run is called hung
	localparam int         IDLE_LIMIT = 4000;
	// cycles the result side stays stalled in each long hold-off
	localparam int         HOLD_LEN   = 250;
	// settle time after the last expected result
	localparam int         DRAIN      = 30;

	// how a request's expected result is obtained
	typedef enum logic [1:0] {
		BY_MODEL,    // from the line-state predictor below
		FIXED_NONE,  // typed in: no result
		FIXED_RES    // typed in: exactly this result
	} row_check_t;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  b;
		int          reps;
		row_check_t  chk;
		glc_result_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	glc_in_if  feed_ch ();
	glc_out_if res_ch ();

	gcode_line_cleaner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_ch),
		.result (res_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Line-state predictor: mirrors the block's per-line registers
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] line_bytes   = '0;  // source bytes in this line, CR not counted
	logic [LEN_W-1:0] kept_chars   = '0;  // characters kept in this line
	logic [7:0]  paren_level  = '0;  // comment nesting, saturates at DEPTH_MAX
	logic        in_semi      = 1'b0; // rest of line is a ';' comment
	logic        lead_percent = 1'b0; // first kept character was '%'
	logic [31:0] lines_done   = '0;  // source lines ended, wraps
	logic        stuck        = 1'b0; // overlong line seen, waits for restart

	function automatic void clear_line_state();
		line_bytes   = '0;
		kept_chars   = '0;
		paren_level  = '0;
		in_semi      = 1'b0;
		lead_percent = 1'b0;
	endfunction

	// Close the current line and build its verdict
	function automatic glc_result_t close_line();
		glc_result_t r;
		r = '0;
		r.kind = (kept_chars != 0 && !(kept_chars == 1 && lead_percent)) ?
			KIND_ACCEPT : KIND_DISCARD;
		r.kept_length = sat_len(kept_chars);
		lines_done = lines_done + 32'd1;
		r.line_number = lines_done;
		clear_line_state();
		return r;
	endfunction

	// Advance the predictor by one accepted request; returns 1 when a result is due
	function automatic bit clean_request(input logic [1:0] op, input logic [7:0] b,
		output glc_result_t r);
		r = '0;
		if (op == OP_RESTART) begin
			clear_line_state();
			lines_done = '0;
			stuck = 1'b0;
			return 1'b0;
		end
		if (op == OP_UNUSED || stuck)
			return 1'b0;
		if (op == OP_FLUSH) begin
			if (line_bytes == 0)
				return 1'b0;
			r = close_line();
			return 1'b1;
		end
		if (b == CH_CR)
			return 1'b0;
		if (b == CH_LF) begin
			r = close_line();
			return 1'b1;
		end
		// byte past the limit: fatal, nothing else changes
		if (int'(line_bytes) >= MAX_LINE) begin
			stuck = 1'b1;
			r.kind = KIND_TOO_LONG;
			r.line_number = lines_done;
			r.kept_length = sat_len(kept_chars);
			return 1'b1;
		end
		line_bytes = line_bytes + LEN_W'(1);
		if (in_semi)
			return 1'b0;
		if (b == CH_LPAREN) begin
			if (paren_level != DEPTH_MAX)
				paren_level = paren_level + 8'd1;
			return 1'b0;
		end
		if (b == CH_RPAREN) begin
			// a stray close paren at depth zero is just dropped
			if (paren_level != 0)
				paren_level = paren_level - 8'd1;
			return 1'b0;
		end
		if (paren_level != 0)
			return 1'b0;
		if (b == CH_SEMI) begin
			in_semi = 1'b1;
			return 1'b0;
		end
		if (b <= CH_SPACE)
			return 1'b0;
		if (kept_chars == 0)
			lead_percent = (b == CH_PERCENT);
		kept_chars = kept_chars + LEN_W'(1);
		r.kind = KIND_CHAR;
		r.out_char = b;
		r.line_number = lines_done;
		r.kept_length = sat_len(kept_chars);
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: predict on every accepted request, check every result
	// ------------------------------------------------------------------
	glc_result_t expected_results[$];
	row_check_t  req_check;      // travels with the request on the feed channel
	glc_result_t req_fixed;
	int          mismatches     = 0;
	int          requests_sent  = 0;
	int          results_seen   = 0;
	int          lines_closed   = 0;
	int          overlong_hits  = 0;
	int          stall_cycles   = 0;  // cycles the feed side was held back
	int          idle_cycles    = 0;

	always @(posedge clk) begin
		glc_result_t got, want, pred;
		bit          due;
		if (arst_n) begin
			// results first: anything on the wire now came from an earlier request
			if (res_ch.valid && res_ch.ready) begin
				got.kind        = res_ch.kind;
				got.out_char    = res_ch.out_char;
				got.line_number = res_ch.line_number;
				got.kept_length = res_ch.kept_length;
				results_seen++;
				if (got.kind == KIND_ACCEPT || got.kind == KIND_DISCARD)
					lines_closed++;
				if (got.kind == KIND_TOO_LONG)
					overlong_hits++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d char %02h line %0d len %0d",
							got.kind, got.out_char, got.line_number, got.kept_length);
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.out_char !== want.out_char ||
						got.line_number !== want.line_number ||
						got.kept_length !== want.kept_length) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected kind %0d char %02h line %0d len %0d,",
								" got kind %0d char %02h line %0d len %0d"},
								want.kind, want.out_char, want.line_number, want.kept_length,
								got.kind, got.out_char, got.line_number, got.kept_length);
					end
				end
			end
			if (feed_ch.valid && feed_ch.ready) begin
				// the predictor always advances; typed rows override its verdict
				due = clean_request(feed_ch.op, feed_ch.in_byte, pred);
				case (req_check)
					BY_MODEL: begin
						if (due)
							expected_results.push_back(pred);
					end
					FIXED_RES: begin
						expected_results.push_back(req_fixed);
					end
					default: begin
					end
				endcase
			end
			if (feed_ch.valid && !feed_ch.ready)
				stall_cycles++;
		end
	end

	// Watchdog: counts cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((feed_ch.valid && feed_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles, %0d results outstanding",
				idle_cycles, expected_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Result side: stall pattern of its own plus long hold-offs
	// ------------------------------------------------------------------
	logic hold_off = 1'b0;
	int   rx_cycle = 0;
	int   rx_mode  = 0;

	always @(negedge clk) begin
		logic rdy;
		rx_cycle++;
		if (rx_cycle % 97 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: rdy = 1'b1;                              // no stalls at all
			1: rdy = 1'($urandom_range(0, 1));          // coin flip
			2: rdy = (rx_cycle % 4 == 0);               // one cycle in four
			default: rdy = ($urandom_range(0, 7) != 0); // rare stalls
		endcase
		if (hold_off)
			rdy = 1'b0;
		res_ch.ready = rdy;
	end

	// Two long hold-offs while the feed keeps offering requests, so the
	// result stage fills and the block drops feed.ready
	initial begin
		for (int k = 1; k <= 2; k++) begin
			wait (requests_sent >= k * 500);
			@(negedge clk);
			hold_off = 1'b1;
			repeat (HOLD_LEN) @(negedge clk);
			hold_off = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Feed side: bursts of random length with random gaps
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic push_request(input logic [1:0] op, input logic [7:0] b,
		input row_check_t chk = BY_MODEL, input glc_result_t fixed = '0);
		int gap;
		@(negedge clk);
		feed_ch.valid   = 1'b1;
		feed_ch.op      = op;
		feed_ch.in_byte = b;
		req_check       = chk;
		req_fixed       = fixed;
		do
			@(posedge clk);
		while (!feed_ch.ready);
		if (op != OP_UNUSED)
			requests_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			feed_ch.valid = 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// One byte of line body: mostly G-code words, with comments, blanks and odd bytes
	function automatic logic [7:0] body_char();
		string       words;
		int          s;
		logic [7:0]  c;
		words = "GXYZFMSIJKT0123456789.-";
		s = $urandom_range(0, 99);
		if (s < 45)
			c = words[$urandom_range(0, words.len() - 1)];
		else if (s < 52)
			c = CH_SPACE;
		else if (s < 55)
			c = 8'h09;
		else if (s < 62)
			c = CH_LPAREN;
		else if (s < 69)
			c = CH_RPAREN;
		else if (s < 73)
			c = CH_SEMI;
		else if (s < 77)
			c = CH_PERCENT;
		else if (s < 81)
			c = CH_CR;
		else if (s < 85)
			c = 8'($urandom_range(0, 31));
		else if (s < 92)
			c = 8'($urandom_range(128, 255));
		else
			c = 8'($urandom_range(0, 255));
		// a newline here would cut the line short
		if (c == CH_LF)
			c = 8'h00;
		return c;
	endfunction

	// One source line: mostly short, some right at the limit, a few past it
	task automatic random_line();
		int sel, len, t;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			len = $urandom_range(MAX_LINE + 1, MAX_LINE + 6);
		else if (sel < 8)
			len = $urandom_range(MAX_LINE - 16, MAX_LINE);
		else if (sel < 18)
			len = $urandom_range(0, 2);
		else
			len = $urandom_range(1, 24);
		// short lines led by '%' can hit the program-marker discard
		if (sel >= 8 && sel < 18)
			push_request(OP_BYTE, CH_PERCENT);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) == 0)
				push_request(OP_UNUSED, 8'($urandom_range(0, 255)));
			push_request(OP_BYTE, body_char());
		end
		if (sel < 3) begin
			// halted (unless CRs kept the count down): byte, flush and newline are ignored, the restart clears the halt
			push_request(OP_BYTE, body_char());
			push_request(OP_FLUSH, 8'($urandom_range(0, 255)));
			push_request(OP_BYTE, CH_LF);
			push_request(OP_RESTART, 8'($urandom_range(0, 255)));
			return;
		end
		t = $urandom_range(0, 99);
		if (t < 78) begin
			push_request(OP_BYTE, CH_LF);
		end else if (t < 88) begin
			push_request(OP_BYTE, CH_CR);
			push_request(OP_BYTE, CH_LF);
		end else if (t < 95) begin
			push_request(OP_FLUSH, 8'($urandom_range(0, 255)));
			// a second flush finds an empty line
			if ($urandom_range(0, 1))
				push_request(OP_FLUSH, 8'($urandom_range(0, 255)));
		end else if (t < 98) begin
			push_request(OP_RESTART, 8'($urandom_range(0, 255)));
		end else begin
			push_request(OP_UNUSED, 8'($urandom_range(0, 255)));
			push_request(OP_BYTE, CH_LF);
		end
	endtask

	function automatic dir_row_t row(input logic [1:0] op, input logic [7:0] b,
		input int reps, input row_check_t chk, input glc_kind_t kind = KIND_CHAR,
		input logic [7:0] ch = '0, input logic [31:0] line = '0, input logic [8:0] klen = '0);
		dir_row_t r;
		r.op   = op;
		r.b    = b;
		r.reps = reps;
		r.chk  = chk;
		r.res  = '{kind: kind, out_char: ch, line_number: line, kept_length: klen};
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		dir_row_t dir_rows[$];
		arst_n          = 1'b0;
		feed_ch.valid   = 1'b0;
		feed_ch.op      = OP_BYTE;
		feed_ch.in_byte = '0;
		req_check       = BY_MODEL;
		req_fixed       = '0;

		// walk-through after reset; expected values read straight off the rules
		dir_rows.push_back(row(OP_BYTE, "G", 1, FIXED_RES, KIND_CHAR, "G", 0, 1));
		dir_rows.push_back(row(OP_BYTE, CH_SPACE, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_BYTE, CH_LPAREN, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_BYTE, "X", 1, FIXED_NONE));           // inside parens
		dir_rows.push_back(row(OP_BYTE, CH_RPAREN, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_BYTE, CH_RPAREN, 1, FIXED_NONE));     // stray close
		dir_rows.push_back(row(OP_BYTE, 8'h00, 1, FIXED_NONE));         // zero byte
		dir_rows.push_back(row(OP_BYTE, 8'hFF, 1, FIXED_RES, KIND_CHAR, 8'hFF, 0, 2));
		dir_rows.push_back(row(OP_BYTE, CH_CR, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_BYTE, CH_SEMI, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_BYTE, "Z", 1, FIXED_NONE));           // after ';'
		dir_rows.push_back(row(OP_BYTE, CH_LF, 1, FIXED_RES, KIND_ACCEPT, 0, 1, 2));
		dir_rows.push_back(row(OP_BYTE, CH_PERCENT, 1, FIXED_RES, KIND_CHAR, CH_PERCENT, 1, 1));
		dir_rows.push_back(row(OP_BYTE, CH_LF, 1, FIXED_RES, KIND_DISCARD, 0, 2, 1));
		dir_rows.push_back(row(OP_BYTE, CH_LF, 1, FIXED_RES, KIND_DISCARD, 0, 3, 0));
		dir_rows.push_back(row(OP_FLUSH, 8'h00, 1, FIXED_NONE));        // empty partial line
		dir_rows.push_back(row(OP_UNUSED, 8'hA5, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_BYTE, "A", 1, FIXED_RES, KIND_CHAR, "A", 3, 1));
		dir_rows.push_back(row(OP_FLUSH, 8'hFF, 1, FIXED_RES, KIND_ACCEPT, 0, 4, 1));
		dir_rows.push_back(row(OP_BYTE, 8'h1F, 1, FIXED_NONE));         // top control byte
		dir_rows.push_back(row(OP_BYTE, 8'h80, 1, FIXED_RES, KIND_CHAR, 8'h80, 4, 1));
		dir_rows.push_back(row(OP_RESTART, 8'hFF, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_BYTE, CH_LF, 1, FIXED_RES, KIND_DISCARD, 0, 1, 0));
		// a full line of open parens saturates the depth, the next byte overflows
		dir_rows.push_back(row(OP_BYTE, CH_LPAREN, MAX_LINE, BY_MODEL));
		dir_rows.push_back(row(OP_BYTE, "B", 1, FIXED_RES, KIND_TOO_LONG, 0, 1, 0));
		dir_rows.push_back(row(OP_BYTE, "C", 1, FIXED_NONE));           // halted
		dir_rows.push_back(row(OP_FLUSH, 8'h00, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_BYTE, CH_LF, 1, FIXED_NONE));
		dir_rows.push_back(row(OP_RESTART, 8'h00, 1, FIXED_NONE));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			for (int n = 0; n < dir_rows[i].reps; n++)
				push_request(dir_rows[i].op, dir_rows[i].b, dir_rows[i].chk, dir_rows[i].res);

		while (requests_sent < ITEMS)
			random_line();

		@(negedge clk);
		feed_ch.valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d lines closed, %0d overlong",
			requests_sent, results_seen, lines_closed, overlong_hits);
		$display("feed held back for %0d cycles, %0d mismatches", stall_cycles, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
